// ===== sv/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg: shared types and constants of the 3x3 image filter
// Register codes, window tap geometry and the per-beat control record that
// travels down the filter pipeline.
// ----------------------------------------------------------------------------
package c3f_pkg;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int TAPS       = 9;
  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = 25;
  localparam int ROW_SUM_W  = 27;
  localparam int TOTAL_W    = 29;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TOP = 3'd0,
    REG_COEF_MID = 3'd1,
    REG_COEF_BOT = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_CHANNELS = 3'd5
  } c3f_reg_e;

  localparam logic [47:0] COEF_RST     = 48'd0;
  localparam logic [10:0] WIDTH_RST    = 11'd512;
  localparam logic [12:0] HEIGHT_RST   = 13'd512;
  localparam logic [2:0]  CHANNELS_RST = 3'd4;

  // Window tap k sits at row k/3 and column k%3. Row 0 holds the newest line
  // (dy = +1), column 0 the newest pixel (dx = +1); tap 4 is the centre.
  localparam logic [1:0] TAP_ROW [TAPS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
                                            2'd2, 2'd2, 2'd2};
  localparam logic [1:0] TAP_COL [TAPS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
                                            2'd0, 2'd1, 2'd2};
  localparam int CENTRE_TAP = 4;

  typedef struct packed {
    logic       vld;
    logic       border;
    logic       fend;
    logic [3:0] fmask;
  } c3f_meta_t;

endpackage

// ===== sv/c3f_pix_if.sv =====
// ----------------------------------------------------------------------------
// c3f_pix_if: input pixel channel
// Valid/ready channel carrying one pixel of up to four channels or a drain.
// ----------------------------------------------------------------------------
interface c3f_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_c0;
  logic [7:0] pix_c1;
  logic [7:0] pix_c2;
  logic [7:0] pix_c3;
  logic       drain;

  modport source (output valid, pix_c0, pix_c1, pix_c2, pix_c3, drain, input ready);
  modport sink   (input valid, pix_c0, pix_c1, pix_c2, pix_c3, drain, output ready);
endinterface

// ===== sv/c3f_res_if.sv =====
// ----------------------------------------------------------------------------
// c3f_res_if: output pixel channel
// Valid/ready channel carrying one filtered pixel and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface c3f_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_c0;
  logic [7:0] out_c1;
  logic [7:0] out_c2;
  logic [7:0] out_c3;
  logic       frame_end;

  modport source (output valid, out_c0, out_c1, out_c2, out_c3, frame_end, input ready);
  modport sink   (input valid, out_c0, out_c1, out_c2, out_c3, frame_end, output ready);
endinterface

// ===== sv/conv3x3_image_filter_unit.sv =====
// ----------------------------------------------------------------------------
// conv3x3_image_filter_unit: streaming 3x3 correlation filter
// Raster pixels in, filtered pixels out, one row plus one pixel behind.
// ----------------------------------------------------------------------------
// A pixel beat is taken every clock in steady state, and results leave at the
// same rate, passing pipeline registers B, C and D and the output register
// after the beat that completes their neighbourhood. The history of the last
// 2*MAX_WIDTH+3 pixels lives in a memory with one write and two read ports;
// while pixels stream, the two ports fetch the lines one and two rows up for
// the next pixel, and a chain of three column cells holds the 3x3 window.
// Some results cannot use the window: every drain beat that flushes a result,
// and a pixel that completes a result while the window is not aligned with it
// (the first two pixels after reset or after an image_width write, or a
// backlog left by a narrower width). Those fetch their nine taps through the
// two read ports, and no input beat is taken meanwhile; the lines for the
// next pixel are fetched again before input resumes. A configuration write
// also holds input off in the cycle after it. A finished result waits in the
// output register without stopping the next input beat unless that register
// is full and not being taken.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int CHANNELS   = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  c3f_pix_if.sink                          pix_if,
  c3f_res_if.source                        res_if,
  input  logic                             cfg_we_i,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int AW         = $clog2(HIST_DEPTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int PW         = $clog2(MAX_WIDTH + 2);
  localparam int WORD_W     = 8 * CHANNELS;
  localparam int TAPS       = c3f_pkg::TAPS;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_READ, SEQ_HOLD} seq_state_e;

  // Configuration registers.
  logic [47:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= c3f_pkg::COEF_RST;
      coef_mid_q <= c3f_pkg::COEF_RST;
      coef_bot_q <= c3f_pkg::COEF_RST;
      width_q    <= c3f_pkg::WIDTH_RST;
      height_q   <= c3f_pkg::HEIGHT_RST;
      chan_q     <= c3f_pkg::CHANNELS_RST;
    end else if (cfg_we_i) begin
      case (c3f_pkg::c3f_reg_e'(cfg_idx_i))
        c3f_pkg::REG_COEF_TOP: coef_top_q <= cfg_data_i;
        c3f_pkg::REG_COEF_MID: coef_mid_q <= cfg_data_i;
        c3f_pkg::REG_COEF_BOT: coef_bot_q <= cfg_data_i;
        c3f_pkg::REG_WIDTH:    width_q    <= cfg_data_i[10:0];
        c3f_pkg::REG_HEIGHT:   height_q   <= cfg_data_i[12:0];
        c3f_pkg::REG_CHANNELS: chan_q     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // The geometry in use is clamped between three and MAX_WIDTH or MAX_HEIGHT.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_q < 11'd3) begin
      w_eff = WW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < 13'd3) begin
      h_eff = HW'(3);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  // Stream state.
  logic [AW-1:0] wr_q, wr_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [CW-1:0] ocol_q, ocol_d;
  logic [RW-1:0] orow_q, orow_d;
  logic [1:0]    stale_q, stale_d;
  logic          pf_ok_q;
  logic          en;
  logic          in_rdy;
  seq_state_e    seq_state_q;

  logic [3:0][7:0]   in_pix;
  logic [WORD_W-1:0] in_word;
  logic              acc, is_pix, is_drn;
  logic              pend_full, pend_at_w;
  logic              emit_any, use_shift, start_seq;
  logic [AW-1:0]     ctr;
  c3f_pkg::c3f_meta_t dec_meta;
  logic              col_last;

  assign en      = !res_if.valid || res_if.ready;
  assign in_rdy  = en && (seq_state_q == SEQ_IDLE) && pf_ok_q;
  assign pix_if.ready = in_rdy;

  assign in_pix  = {pix_if.pix_c3, pix_if.pix_c2, pix_if.pix_c1, pix_if.pix_c0};
  assign in_word = WORD_W'(in_pix);

  assign acc    = pix_if.valid && in_rdy;
  assign is_pix = acc && !pix_if.drain;
  assign is_drn = acc && pix_if.drain;

  // A pixel completes a result once at least width+1 pixels are waiting.
  assign pend_full = 32'(pend_q) >= 32'(w_eff) + 1;
  assign pend_at_w = 32'(pend_q) == 32'(w_eff) + 1;
  assign emit_any  = (is_pix && pend_full) || (is_drn && (pend_q != '0));
  assign use_shift = is_pix && pend_at_w && (stale_q == 2'd0);
  assign start_seq = emit_any && !use_shift;

  always_comb begin
    int pos;
    pos = int'(wr_q) - int'(pend_q);
    if (pos < 0) begin
      pos = pos + HIST_DEPTH;
    end
    ctr = AW'(pos);
  end

  // Output position, border test and frame end for the result decided now.
  always_comb begin
    dec_meta.vld    = 1'b1;
    dec_meta.border = (orow_q == '0) || (32'(orow_q) >= 32'(h_eff) - 1)
                   || (ocol_q == '0) || (32'(ocol_q) >= 32'(w_eff) - 1);
    dec_meta.fend   = (32'(orow_q) == 32'(h_eff) - 1) && (32'(ocol_q) == 32'(w_eff) - 1);
    for (int g = 0; g < 4; g++) begin
      dec_meta.fmask[g] = 32'(chan_q) > g;
    end
    col_last = 32'(ocol_q) + 1 >= 32'(w_eff);
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    if (emit_any) begin
      if (col_last) begin
        ocol_d = '0;
        orow_d = (32'(orow_q) + 1 >= 32'(h_eff)) ? '0 : RW'(orow_q + 1'b1);
      end else begin
        ocol_d = CW'(ocol_q + 1'b1);
      end
    end
  end

  always_comb begin
    wr_d    = wr_q;
    pend_d  = pend_q;
    stale_d = stale_q;
    if (is_pix) begin
      wr_d = (32'(wr_q) == HIST_DEPTH - 1) ? '0 : AW'(wr_q + 1'b1);
      if (!pend_full) begin
        pend_d = PW'(pend_q + 1'b1);
      end
      if (stale_q != 2'd0) begin
        stale_d = stale_q - 2'd1;
      end
    end else if (is_drn && (pend_q != '0)) begin
      pend_d = PW'(pend_q - 1'b1);
    end
    // A new width invalidates the upper lines held in the window.
    if (cfg_we_i && (c3f_pkg::c3f_reg_e'(cfg_idx_i) == c3f_pkg::REG_WIDTH)) begin
      stale_d = 2'd2;
    end
  end

  // Tap sequencer state.
  logic [2:0]        seq_step_q;
  logic [AW-1:0]     seq_ctr_q;
  c3f_pkg::c3f_meta_t seq_meta_q;
  logic [WORD_W-1:0] seq_win_q [TAPS];
  logic              seq_reading;
  logic              inject;
  logic [3:0]        k_a, k_b;

  assign seq_reading = (seq_state_q == SEQ_READ) && (seq_step_q != 3'd5);
  assign inject      = (seq_state_q == SEQ_HOLD) && en;
  assign k_a         = {seq_step_q, 1'b0};
  assign k_b         = (seq_step_q == 3'd4) ? 4'd8 : {seq_step_q, 1'b1};

  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] c, input logic [3:0] k,
                                             input logic [WW-1:0] w);
    int pos;
    pos = int'(c);
    case (c3f_pkg::TAP_ROW[k])
      2'd0:    pos = pos + int'(w);
      2'd2:    pos = pos - int'(w);
      default: ;
    endcase
    case (c3f_pkg::TAP_COL[k])
      2'd0:    pos = pos + 1;
      2'd2:    pos = pos - 1;
      default: ;
    endcase
    if (pos < 0) begin
      pos = pos + HIST_DEPTH;
    end else if (pos >= HIST_DEPTH) begin
      pos = pos - HIST_DEPTH;
    end
    return AW'(pos);
  endfunction

  // History memory. Outside the sequencer the ports prefetch the pixels one
  // and two lines above the next write position.
  logic [WORD_W-1:0] hist_mem [HIST_DEPTH];
  logic [WORD_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]     rd_addr_a, rd_addr_b;

  always_comb begin
    int pa, pb;
    pa = int'(wr_d) - int'(w_eff);
    pb = int'(wr_d) - 2 * int'(w_eff);
    if (pa < 0) begin
      pa = pa + HIST_DEPTH;
    end
    if (pb < 0) begin
      pb = pb + HIST_DEPTH;
    end
    if (seq_reading) begin
      rd_addr_a = tap_addr(seq_ctr_q, k_a, w_eff);
      rd_addr_b = tap_addr(seq_ctr_q, k_b, w_eff);
    end else begin
      rd_addr_a = AW'(pa);
      rd_addr_b = AW'(pb);
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_pix) begin
      hist_mem[wr_q] <= in_word;
    end
    rd_a_q <= hist_mem[rd_addr_a];
    rd_b_q <= hist_mem[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      pend_q  <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      stale_q <= 2'd2;
      pf_ok_q <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      pend_q  <= pend_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      stale_q <= stale_d;
      pf_ok_q <= !seq_reading && !cfg_we_i;
    end
  end

  // Sequencer: two taps are read per cycle and land in the window at the following step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q <= SEQ_IDLE;
      seq_step_q  <= '0;
      seq_ctr_q   <= '0;
      seq_meta_q  <= '0;
      for (int k = 0; k < TAPS; k++) begin
        seq_win_q[k] <= '0;
      end
    end else begin
      case (seq_state_q)
        SEQ_IDLE: begin
          if (start_seq) begin
            seq_state_q <= SEQ_READ;
            seq_step_q  <= '0;
            seq_ctr_q   <= ctr;
            seq_meta_q  <= dec_meta;
          end
        end
        SEQ_READ: begin
          if (seq_step_q != 3'd0) begin
            seq_win_q[4'({seq_step_q, 1'b0} - 4'd2)] <= rd_a_q;
            if (seq_step_q != 3'd5) begin
              seq_win_q[4'({seq_step_q, 1'b0} - 4'd1)] <= rd_b_q;
            end
          end
          if (seq_step_q == 3'd5) begin
            seq_state_q <= SEQ_HOLD;
          end else begin
            seq_step_q <= seq_step_q + 3'd1;
          end
        end
        SEQ_HOLD: begin
          if (en) begin
            seq_state_q <= SEQ_IDLE;
          end
        end
        default: seq_state_q <= SEQ_IDLE;
      endcase
    end
  end

  // Window: a chain of three column cells, newest column in cell 0.
  logic [2:0][2:0][WORD_W-1:0] col;
  logic [2:0][WORD_W-1:0]      col_new;

  assign col_new = {rd_b_q, rd_a_q, in_word};

  for (genvar j = 0; j < 3; j++) begin : g_cell
    c3f_col_cell #(.WORD_W(WORD_W)) u_cell (
      .clk_i   (clk_i),
      .shift_i (is_pix),
      .col_i   ((j == 0) ? col_new : col[(j == 0) ? 0 : j - 1]),
      .col_o   (col[j])
    );
  end

  // Pipeline control: B holds the result waiting for the multipliers,
  // C and D follow the two register stages inside the lanes.
  c3f_pkg::c3f_meta_t b_q, b_d, c_q, d_q;
  logic               b_seq_q;
  logic [WORD_W-1:0]  c_cen_q, d_cen_q;
  logic [WORD_W-1:0]  win_sel [TAPS];

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      win_sel[k] = b_seq_q ? seq_win_q[k]
                           : col[c3f_pkg::TAP_COL[k]][c3f_pkg::TAP_ROW[k]];
    end
  end

  always_comb begin
    b_d     = inject ? seq_meta_q : dec_meta;
    b_d.vld = use_shift || inject;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      b_seq_q <= 1'b0;
    end else if (en) begin
      b_q     <= b_d;
      b_seq_q <= inject;
      c_q     <= b_q;
      d_q     <= c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_cen_q <= win_sel[c3f_pkg::CENTRE_TAP];
      d_cen_q <= c_cen_q;
    end
  end

  // Weights by tap: the top line of the image is the oldest window line.
  logic [TAPS-1:0][c3f_pkg::COEF_W-1:0] wgt;

  always_comb begin
    logic [47:0] rowv;
    for (int k = 0; k < TAPS; k++) begin
      case (c3f_pkg::TAP_ROW[k])
        2'd0:    rowv = coef_bot_q;
        2'd1:    rowv = coef_mid_q;
        default: rowv = coef_top_q;
      endcase
      wgt[k] = rowv[16 * (2 - int'(c3f_pkg::TAP_COL[k])) +: 16];
    end
  end

  logic [3:0][7:0] out_d;
  logic [3:0][7:0] out_q;
  logic            out_vld_q;
  logic            out_fend_q;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      logic [TAPS-1:0][7:0] lane_pix;
      logic [7:0]           lane_res;

      always_comb begin
        for (int k = 0; k < TAPS; k++) begin
          lane_pix[k] = win_sel[k][8*g +: 8];
        end
      end

      c3f_lane u_lane (
        .clk_i (clk_i),
        .en_i  (en),
        .pix_i (lane_pix),
        .wgt_i (wgt),
        .res_o (lane_res)
      );

      assign out_d[g] = (d_q.border || !d_q.fmask[g]) ? d_cen_q[8*g +: 8] : lane_res;
    end else begin : g_off
      assign out_d[g] = 8'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_fend_q <= d_q.fend;
    end
  end

  assign res_if.valid     = out_vld_q;
  assign res_if.out_c0    = out_q[0];
  assign res_if.out_c1    = out_q[1];
  assign res_if.out_c2    = out_q[2];
  assign res_if.out_c3    = out_q[3];
  assign res_if.frame_end = out_fend_q;

endmodule

// ===== sv/c3f_col_cell.sv =====
// ----------------------------------------------------------------------------
// c3f_col_cell: one column of the 3x3 window
// Holds three pixel words, one per line, and hands them to the next cell.
// ----------------------------------------------------------------------------
module c3f_col_cell #(
  parameter int WORD_W = 32
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [2:0][WORD_W-1:0] col_i,
  output logic [2:0][WORD_W-1:0] col_o
);

  logic [2:0][WORD_W-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== sv/c3f_lane.sv =====
// ----------------------------------------------------------------------------
// c3f_lane: multiply-accumulate lane for one colour channel
// Nine products, then three line sums, then magnitude, scale and clip.
// ----------------------------------------------------------------------------
module c3f_lane (
  input  logic                                             clk_i,
  input  logic                                             en_i,
  input  logic [c3f_pkg::TAPS-1:0][7:0]                    pix_i,
  input  logic [c3f_pkg::TAPS-1:0][c3f_pkg::COEF_W-1:0]    wgt_i,
  output logic [7:0]                                       res_o
);

  logic signed [c3f_pkg::PROD_W-1:0]    prod_q [c3f_pkg::TAPS];
  logic signed [c3f_pkg::ROW_SUM_W-1:0] row_q  [3];
  logic signed [c3f_pkg::TOTAL_W-1:0]   total;
  logic        [c3f_pkg::TOTAL_W-1:0]   mag;
  logic        [c3f_pkg::TOTAL_W-1:0]   scaled;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < c3f_pkg::TAPS; k++) begin
        prod_q[k] <= $signed({1'b0, pix_i[k]}) * $signed(wgt_i[k]);
      end
      for (int r = 0; r < 3; r++) begin
        row_q[r] <= {{2{prod_q[3*r][c3f_pkg::PROD_W-1]}}, prod_q[3*r]}
                  + {{2{prod_q[3*r+1][c3f_pkg::PROD_W-1]}}, prod_q[3*r+1]}
                  + {{2{prod_q[3*r+2][c3f_pkg::PROD_W-1]}}, prod_q[3*r+2]};
      end
    end
  end

  always_comb begin
    total = {{2{row_q[0][c3f_pkg::ROW_SUM_W-1]}}, row_q[0]}
          + {{2{row_q[1][c3f_pkg::ROW_SUM_W-1]}}, row_q[1]}
          + {{2{row_q[2][c3f_pkg::ROW_SUM_W-1]}}, row_q[2]};
    mag    = total[c3f_pkg::TOTAL_W-1] ? c3f_pkg::TOTAL_W'(-total) : c3f_pkg::TOTAL_W'(total);
    scaled = mag >> c3f_pkg::FRAC_BITS;
    res_o  = (scaled > c3f_pkg::TOTAL_W'(255)) ? 8'd255 : scaled[7:0];
  end

endmodule

// ===== sv/c3f_checker.sv =====
// ----------------------------------------------------------------------------
// c3f_checker: port-level checks of the 3x3 image filter
// Watches the handshakes and the configuration port of the top level.
// ----------------------------------------------------------------------------
module c3f_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_c0,
  input logic       frame_end,
  input logic       cfg_we
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_c0) && $stable(frame_end))
    else $error("stalled result beat changed");

  // A full, stalled output register stops the input side.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the output is stalled");

  // After a configuration write the line prefetch is redone before input.
  a_cfg_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> !in_ready)
    else $error("input taken straight after a configuration write");

endmodule

bind conv3x3_image_filter_unit c3f_checker u_c3f_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (pix_if.ready),
  .out_valid (res_if.valid),
  .out_ready (res_if.ready),
  .out_c0    (res_if.out_c0),
  .frame_end (res_if.frame_end),
  .cfg_we    (cfg_we_i)
);
